/* sv/csv_pkg.sv */
// Shared constants, register codes and cell control type for the 2-D convolution block.
// Used by the channel interfaces, the tap/MAC cells and the top level.
`default_nettype none

package csv_pkg;

	localparam int MAX_DIM_DEF    = 64;
	localparam int MAX_KERNEL_DEF = 5;
	localparam int PIXEL_BITS_DEF = 16;

	localparam int SUM_BITS      = 37;
	localparam int POS_BITS      = 6;
	localparam int OP_BITS       = 2;
	localparam int TAP_IDX_BITS  = 5;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 7;
	localparam int DIM_REG_BITS  = 7;
	localparam int KERN_REG_BITS = 3;

	localparam logic [OP_BITS-1:0] OP_TAP   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_PIXEL = 2'd1;
	localparam logic [OP_BITS-1:0] OP_FLUSH = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_PAD_MODE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_ROWS  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAP_COLS  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERN_ROWS = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_KERN_COLS = 3'd4;

	localparam logic [DIM_REG_BITS-1:0]  MAP_DIM_RST  = 7'd64;
	localparam logic [KERN_REG_BITS-1:0] KERN_DIM_RST = 3'd3;

	typedef struct packed {
		logic shift;    // pixel chain moves one cell on
		logic capture;  // cells register tap * pixel
		logic tap_we;   // tap store write
	} cell_ctl_t;

endpackage

`default_nettype wire

/* sv/csv_ifs.sv */
// Valid/ready channel interfaces for input items and result pixels.
// Depends on csv_pkg for field widths.
`default_nettype none

interface csv_in_if import csv_pkg::*; #(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [OP_BITS-1:0]           operation;
	logic [TAP_IDX_BITS-1:0]      tap_index;
	logic signed [PIXEL_BITS-1:0] sample_value;

	modport source(output valid, operation, tap_index, sample_value, input ready);
	modport sink(input valid, operation, tap_index, sample_value, output ready);
endinterface

interface csv_out_if import csv_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SUM_BITS-1:0] sum_value;
	logic [POS_BITS-1:0]        result_row;
	logic [POS_BITS-1:0]        result_col;
	logic                       frame_done;

	modport source(output valid, sum_value, result_row, result_col, frame_done, input ready);
	modport sink(input valid, sum_value, result_row, result_col, frame_done, output ready);
endinterface

`default_nettype wire

/* sv/csv_cell.sv */
// One kernel-column cell: own copy of the tap store, a pixel stage of the shift chain,
// a product register and a partial-sum stage handed on to the next cell. Uses csv_pkg.
`default_nettype none

module csv_cell import csv_pkg::*; #(
	parameter int CELL_ID    = 0,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int TIW        = 5,
	parameter int KW         = 3
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cell_ctl_t                    ctl,
	input  wire logic [TIW-1:0]               tap_widx,
	input  wire logic signed [PIXEL_BITS-1:0] tap_wdata,
	input  wire logic [TIW-1:0]               row_base,
	input  wire logic [KW-1:0]                kern_cols,
	input  wire logic signed [PIXEL_BITS-1:0] pix_in,
	output logic signed [PIXEL_BITS-1:0]      pix_out,
	input  wire logic                         tok_in,
	output logic                              tok_out,
	input  wire logic signed [SUM_BITS-1:0]   psum_in,
	output logic signed [SUM_BITS-1:0]        psum_out
);

	localparam int TAP_COUNT = MAX_KERNEL * MAX_KERNEL;
	localparam int PW        = 2 * PIXEL_BITS;

	logic signed [PIXEL_BITS-1:0] tap_q [TAP_COUNT];
	logic signed [PIXEL_BITS-1:0] tap_rd_q;
	logic signed [PIXEL_BITS-1:0] pix_q;
	logic signed [SUM_BITS-1:0]   prod_q;
	logic signed [SUM_BITS-1:0]   psum_q;
	logic                         tok_q;
	logic                         use_tap;
	logic [TIW-1:0]               ridx;
	logic signed [PW-1:0]         prod_w;
	logic signed [PW+SUM_BITS-1:0] prod_ext;

	// cell m holds window column kc-1-m once a kernel row has been shifted in
	assign use_tap = int'(kern_cols) > CELL_ID;
	assign ridx    = TIW'(int'(row_base) + int'(kern_cols) - 1 - CELL_ID);
	assign prod_w  = tap_rd_q * pix_q;
	assign prod_ext = prod_w;

	always_ff @(posedge clk) begin
		if (ctl.tap_we) begin
			tap_q[tap_widx] <= tap_wdata;
		end
		if (use_tap) begin
			tap_rd_q <= tap_q[ridx];
		end
		if (ctl.shift) begin
			pix_q <= pix_in;
		end
		if (ctl.capture) begin
			prod_q <= use_tap ? prod_ext[SUM_BITS-1:0] : '0;
		end
		if (tok_in) begin
			psum_q <= psum_in + prod_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign pix_out  = pix_q;
	assign tok_out  = tok_q;
	assign psum_out = psum_q;

endmodule

`default_nettype wire

/* sv/csv_linebuf.sv */
// Line buffer for the most recent map rows, addressed as {row slot, column}.
// One write and one registered read port. No package dependency.
`default_nettype none

module csv_linebuf #(
	parameter int ROWS_KEPT  = 6,
	parameter int COL_BITS   = 6,
	parameter int PIXEL_BITS = 16,
	localparam int AW        = $clog2(ROWS_KEPT) + COL_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [AW-1:0]                waddr,
	input  wire logic signed [PIXEL_BITS-1:0] wdata,
	input  wire logic                         re,
	input  wire logic [AW-1:0]                raddr,
	output logic signed [PIXEL_BITS-1:0]      rdata
);

	localparam int DEPTH = ROWS_KEPT << COL_BITS;

	logic signed [PIXEL_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/conv2d_same_or_valid.sv */
// Top level of the streaming 2-D convolution: config registers, frame counters,
// window sequencer, line buffer and the chain of kernel-column cells. Uses csv_pkg.
//
//   channel   dir  payload                                         handshake
//   items     in   operation, tap_index, sample_value              valid/ready
//   results   out  sum_value, result_row, result_col, frame_done   valid/ready
//   cfg       in   cfg_index, cfg_data                             cfg_we
//
// Tap loads and dropped items leave the sequencer idle; a pixel or flush that releases nothing
// passes S_CHECK and S_ENDCHK. For a released output, each kernel row is read
// from the line buffer one pixel a cycle, then the partial sum ripples through all cells.
// Reset clears counters, config registers, state and valid flags; memories and datapath registers are not cleared.
// Items are taken while a result waits in the output register; a stalled result stalls
// the sequencer only when the next result is ready to be written.
`default_nettype none

module conv2d_same_or_valid import csv_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	csv_in_if.sink                        items,
	csv_out_if.source                     results,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int ROWS_KEPT = MAX_KERNEL + 1;
	localparam int TAP_COUNT = MAX_KERNEL * MAX_KERNEL;
	localparam int TIW = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int KW  = $clog2(MAX_KERNEL + 1);
	localparam int RCW = $clog2(MAX_DIM + 1);
	localparam int CCW = $clog2(MAX_DIM);
	localparam int SW  = $clog2(ROWS_KEPT);
	localparam int CXW = CCW + KW + 2;
	localparam int AW  = SW + CCW;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_ROWSET, S_ROWRD, S_WAITSH, S_CAPT, S_TOK, S_DRAIN,
		S_FINISH, S_ENDCHK
	} state_t;

	state_t state_q;

	logic                     pad_q;
	logic [DIM_REG_BITS-1:0]  map_rows_q, map_cols_q;
	logic [KERN_REG_BITS-1:0] kern_rows_q, kern_cols_q;

	logic [RCW-1:0] r_dim, c_dim, orows, ocols;
	logic [KW-1:0]  kr, kc;

	logic [RCW-1:0] in_row_q, out_row_q;
	logic [CCW-1:0] in_col_q, out_col_q;
	logic [SW-1:0]  in_slot_q, out_slot_q;

	logic [KW-1:0]         n_q, j_q;
	logic                  row_ok_q;
	logic [SW-1:0]         row_slot_q;
	logic [TIW-1:0]        row_base_q;
	logic signed [CXW-1:0] cc_q;
	logic signed [SUM_BITS-1:0] acc_q;

	logic shift_s1, zero_s1;

	logic                       out_valid_q;
	logic signed [SUM_BITS-1:0] out_sum_q;
	logic [POS_BITS-1:0]        out_row_pos_q, out_col_pos_q;
	logic                       out_done_q;

	logic accept, emit_ok, frame_end, col_ok, rd_zero, out_free, last_tok;
	logic [SW-1:0]         set_slot;
	logic                  set_row_ok;
	logic signed [CXW-1:0] set_cc;
	logic [TIW-1:0]        set_base;

	logic                         pix_we, rd_en;
	logic signed [PIXEL_BITS-1:0] rdata;
	cell_ctl_t                    ctl;

	logic signed [PIXEL_BITS-1:0] pix_c  [MAX_KERNEL+1];
	logic signed [SUM_BITS-1:0]   psum_c [MAX_KERNEL+1];
	logic [MAX_KERNEL:0]          tok_c;

	// clamped sizes and output frame size
	always_comb begin
		int rv, cv, krv, kcv;
		rv  = int'(map_rows_q);
		cv  = int'(map_cols_q);
		krv = int'(kern_rows_q);
		kcv = int'(kern_cols_q);
		if (rv < 1) rv = 1;
		if (rv > MAX_DIM) rv = MAX_DIM;
		if (cv < 1) cv = 1;
		if (cv > MAX_DIM) cv = MAX_DIM;
		if (krv < 1) krv = 1;
		if (krv > MAX_KERNEL) krv = MAX_KERNEL;
		if (kcv < 1) kcv = 1;
		if (kcv > MAX_KERNEL) kcv = MAX_KERNEL;
		r_dim = RCW'(rv);
		c_dim = RCW'(cv);
		kr    = KW'(krv);
		kc    = KW'(kcv);
		if (pad_q) begin
			orows = RCW'(rv);
			ocols = RCW'(cv);
		end else if (krv > rv || kcv > cv) begin
			orows = '0;
			ocols = '0;
		end else begin
			orows = RCW'(rv - krv + 1);
			ocols = RCW'(cv - kcv + 1);
		end
	end

	// next output is released once the last pixel of its window is in
	always_comb begin
		int x, y, rl, cl;
		x = int'(out_row_q);
		y = int'(out_col_q);
		if (pad_q) begin
			rl = x + int'(kr) - 1 - int'(kr >> 1);
			cl = y + int'(kc) - 1 - int'(kc >> 1);
			if (rl > int'(r_dim) - 1) rl = int'(r_dim) - 1;
			if (cl > int'(c_dim) - 1) cl = int'(c_dim) - 1;
		end else begin
			rl = x + int'(kr) - 1;
			cl = y + int'(kc) - 1;
		end
		emit_ok = (x < int'(orows)) && (y < int'(ocols)) &&
			(int'(in_row_q) > rl || (int'(in_row_q) == rl && int'(in_col_q) > cl));
		frame_end = (in_row_q >= r_dim) && (out_row_q >= orows);
	end

	// per kernel row: source row, its slot in the line buffer, first column
	always_comb begin
		int hr, hc, rr, st;
		hr = pad_q ? int'(kr >> 1) : 0;
		hc = pad_q ? int'(kc >> 1) : 0;
		rr = int'(out_row_q) - hr + int'(n_q);
		st = int'(out_slot_q) + int'(n_q) - hr;
		if (st < 0) begin
			st = st + ROWS_KEPT;
		end else if (st >= ROWS_KEPT) begin
			st = st - ROWS_KEPT;
		end
		set_row_ok = !pad_q || (rr >= 0 && rr < int'(r_dim));
		set_slot   = SW'(st);
		set_cc     = CXW'(int'(out_col_q) - hc);
		set_base   = TIW'(int'(n_q) * int'(kc));
	end

	assign col_ok  = !pad_q || (cc_q >= 0 && cc_q < CXW'(c_dim));
	assign rd_zero = !(row_ok_q && col_ok);
	assign rd_en   = (state_q == S_ROWRD) && !rd_zero;

	assign accept   = items.valid && items.ready;
	assign pix_we   = accept && items.operation == OP_PIXEL && in_row_q < r_dim;
	assign out_free = !out_valid_q || results.ready;
	assign last_tok = tok_c[MAX_KERNEL];

	assign ctl.shift   = shift_s1;
	assign ctl.capture = state_q == S_CAPT;
	assign ctl.tap_we  = accept && items.operation == OP_TAP &&
		int'(items.tap_index) < TAP_COUNT;

	assign pix_c[0]  = zero_s1 ? '0 : rdata;
	assign psum_c[0] = acc_q;
	assign tok_c[0]  = state_q == S_TOK;

	csv_linebuf #(
		.ROWS_KEPT (ROWS_KEPT),
		.COL_BITS  (CCW),
		.PIXEL_BITS(PIXEL_BITS)
	) u_linebuf (
		.clk  (clk),
		.we   (pix_we),
		.waddr({in_slot_q, in_col_q}),
		.wdata(items.sample_value),
		.re   (rd_en),
		.raddr(AW'({row_slot_q, cc_q[CCW-1:0]})),
		.rdata(rdata)
	);

	for (genvar m = 0; m < MAX_KERNEL; m++) begin : g_cell
		csv_cell #(
			.CELL_ID   (m),
			.MAX_KERNEL(MAX_KERNEL),
			.PIXEL_BITS(PIXEL_BITS),
			.TIW       (TIW),
			.KW        (KW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.tap_widx (TIW'(items.tap_index)),
			.tap_wdata(items.sample_value),
			.row_base (row_base_q),
			.kern_cols(kc),
			.pix_in   (pix_c[m]),
			.pix_out  (pix_c[m+1]),
			.tok_in   (tok_c[m]),
			.tok_out  (tok_c[m+1]),
			.psum_in  (psum_c[m]),
			.psum_out (psum_c[m+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pad_q       <= 1'b0;
			map_rows_q  <= MAP_DIM_RST;
			map_cols_q  <= MAP_DIM_RST;
			kern_rows_q <= KERN_DIM_RST;
			kern_cols_q <= KERN_DIM_RST;
			in_row_q    <= '0;
			in_col_q    <= '0;
			in_slot_q   <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_slot_q  <= '0;
			n_q         <= '0;
			j_q         <= '0;
			shift_s1    <= 1'b0;
			zero_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			shift_s1 <= state_q == S_ROWRD;
			zero_s1  <= rd_zero;
			if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (items.operation)
							OP_PIXEL: begin
								if (in_row_q < r_dim) begin
									if (RCW'(in_col_q) + 1'b1 >= c_dim) begin
										in_col_q  <= '0;
										in_row_q  <= in_row_q + 1'b1;
										in_slot_q <= (int'(in_slot_q) == ROWS_KEPT - 1) ?
											'0 : in_slot_q + 1'b1;
									end else begin
										in_col_q <= in_col_q + 1'b1;
									end
									state_q <= S_CHECK;
								end
							end
							OP_FLUSH: state_q <= S_CHECK;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CHECK: begin
					if (emit_ok) begin
						n_q     <= '0;
						acc_q   <= '0;
						state_q <= S_ROWSET;
					end else begin
						state_q <= S_ENDCHK;
					end
				end
				S_ROWSET: begin
					row_ok_q   <= set_row_ok;
					row_slot_q <= set_slot;
					row_base_q <= set_base;
					cc_q       <= set_cc;
					j_q        <= '0;
					state_q    <= S_ROWRD;
				end
				S_ROWRD: begin
					cc_q <= cc_q + 1'b1;
					j_q  <= j_q + 1'b1;
					if (j_q == kc - 1'b1) begin
						state_q <= S_WAITSH;
					end
				end
				S_WAITSH: state_q <= S_CAPT;
				S_CAPT:   state_q <= S_TOK;
				S_TOK:    state_q <= S_DRAIN;
				S_DRAIN: begin
					if (last_tok) begin
						acc_q <= psum_c[MAX_KERNEL];
						if (n_q == kr - 1'b1) begin
							state_q <= S_FINISH;
						end else begin
							n_q     <= n_q + 1'b1;
							state_q <= S_ROWSET;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						out_sum_q     <= acc_q;
						out_row_pos_q <= POS_BITS'(out_row_q);
						out_col_pos_q <= POS_BITS'(out_col_q);
						out_done_q    <= (out_row_q == orows - 1'b1) &&
							(RCW'(out_col_q) == ocols - 1'b1);
						if (RCW'(out_col_q) + 1'b1 >= ocols) begin
							out_col_q  <= '0;
							out_row_q  <= out_row_q + 1'b1;
							out_slot_q <= (int'(out_slot_q) == ROWS_KEPT - 1) ?
								'0 : out_slot_q + 1'b1;
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= S_ENDCHK;
					end
				end
				S_ENDCHK: begin
					if (frame_end) begin
						in_row_q   <= '0;
						in_col_q   <= '0;
						in_slot_q  <= '0;
						out_row_q  <= '0;
						out_col_q  <= '0;
						out_slot_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// any write to a defined register restarts the frame
			if (cfg_we && cfg_index <= REG_KERN_COLS) begin
				case (cfg_index)
					REG_PAD_MODE:  pad_q       <= cfg_data[0];
					REG_MAP_ROWS:  map_rows_q  <= cfg_data;
					REG_MAP_COLS:  map_cols_q  <= cfg_data;
					REG_KERN_ROWS: kern_rows_q <= cfg_data[KERN_REG_BITS-1:0];
					REG_KERN_COLS: kern_cols_q <= cfg_data[KERN_REG_BITS-1:0];
					default: pad_q <= pad_q;
				endcase
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_slot_q  <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_slot_q <= '0;
			end
		end
	end

	assign items.ready        = state_q == S_IDLE;
	assign results.valid      = out_valid_q;
	assign results.sum_value  = out_sum_q;
	assign results.result_row = out_row_pos_q;
	assign results.result_col = out_col_pos_q;
	assign results.frame_done = out_done_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_c[MAX_KERNEL:1]))
		else $error("more than one partial sum in flight in the cell chain");

	a_in_col: assert property (@(posedge clk) disable iff (!arst_n)
		RCW'(in_col_q) < c_dim)
		else $error("input column counter past map width");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		int'(in_slot_q) < ROWS_KEPT && int'(out_slot_q) < ROWS_KEPT)
		else $error("line buffer slot out of range");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && out_free |=> out_valid_q && state_q == S_ENDCHK)
		else $error("finished result not placed in output register");

endmodule

`default_nettype wire
